>>> hw/rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and default constants for the minimum tracking FIFO.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefDataWidth = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_XFER_RD,
    S_XFER_WR,
    S_POP,
    S_POP_RD,
    S_RESULT
  } state_e;

endpackage

>>> hw/rtl/min_tracking_fifo.sv
// ----------------------------------------------------------------------------
// min_tracking_fifo
// FIFO of signed values built from two stacks that reports the minimum held.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   operation_i, value_i
// out      output     out_valid_o / out_stall_i taken_value_o, oldest_value_o,
//                                               least_value_o, count_o,
//                                               is_empty_o, error_o
//
// Clear, query and refused transactions go straight to S_RESULT, enqueue via
// S_ENQ, and a dequeue from a filled out-stack via S_POP and S_POP_RD (not
// S_POP_RD when it removes the last out-stack entry). A dequeue finding the
// out-stack empty first moves the in-stack over, each entry via S_XFER_RD
// and S_XFER_WR. Reset empties both stacks at once. The result register lets
// the next transaction be accepted while a result is stalled.
// ----------------------------------------------------------------------------
module min_tracking_fifo import mtf_pkg::*; #(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned DATA_WIDTH = DefDataWidth,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] taken_value_o,
  output logic signed [DATA_WIDTH-1:0] oldest_value_o,
  output logic signed [DATA_WIDTH-1:0] least_value_o,
  output logic [CW-1:0]                count_o,
  output logic                         is_empty_o,
  output logic                         error_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = 2 * DATA_WIDTH;
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);
  localparam logic [CW-1:0] One  = CW'(1);
  localparam logic [CW-1:0] Two  = CW'(2);

  state_e state_q, state_d;
  logic [CW-1:0] in_depth_q, in_depth_d, out_depth_q, out_depth_d;
  logic          out_valid_q, out_valid_d;

  logic signed [DATA_WIDTH-1:0] val_q, val_d;
  logic signed [DATA_WIDTH-1:0] taken_q, taken_d;
  logic                         err_q, err_d;
  logic signed [DATA_WIDTH-1:0] in_top_min_q, in_top_min_d;
  logic signed [DATA_WIDTH-1:0] in_bot_q, in_bot_d;
  logic signed [DATA_WIDTH-1:0] out_top_val_q, out_top_val_d;
  logic signed [DATA_WIDTH-1:0] out_top_min_q, out_top_min_d;

  logic signed [DATA_WIDTH-1:0] res_taken_q, res_taken_d;
  logic signed [DATA_WIDTH-1:0] res_oldest_q, res_oldest_d;
  logic signed [DATA_WIDTH-1:0] res_least_q, res_least_d;
  logic [CW-1:0]                res_count_q, res_count_d;
  logic                         res_error_q, res_error_d;

  logic [CW-1:0] count_w, in_dec, out_dec2;
  logic          in_we, out_we;
  logic [EW-1:0] in_wdata, out_wdata, in_rdata, out_rdata;
  logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b, cmp_y;
  logic signed [DATA_WIDTH-1:0] in_rd_val, out_rd_val, out_rd_min;

  assign count_w   = in_depth_q + out_depth_q;
  assign in_dec    = in_depth_q - One;
  assign out_dec2  = out_depth_q - Two;
  assign in_rd_val = $signed(in_rdata[EW-1:DATA_WIDTH]);
  assign out_rd_val = $signed(out_rdata[EW-1:DATA_WIDTH]);
  assign out_rd_min = $signed(out_rdata[DATA_WIDTH-1:0]);

  mtf_stack_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_in_ram (
    .clk_i  (clk_i),
    .we_i   (in_we),
    .waddr_i(in_depth_q[AW-1:0]),
    .wdata_i(in_wdata),
    .raddr_i(in_dec[AW-1:0]),
    .rdata_o(in_rdata)
  );

  mtf_stack_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_out_ram (
    .clk_i  (clk_i),
    .we_i   (out_we),
    .waddr_i(out_depth_q[AW-1:0]),
    .wdata_i(out_wdata),
    .raddr_i(out_dec2[AW-1:0]),
    .rdata_o(out_rdata)
  );

  mtf_smin #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_smin (
    .a_i(cmp_a),
    .b_i(cmp_b),
    .y_o(cmp_y)
  );

  always_comb begin
    logic signed [DATA_WIDTH-1:0] new_min;
    new_min       = '0;
    state_d       = state_q;
    in_depth_d    = in_depth_q;
    out_depth_d   = out_depth_q;
    out_valid_d   = out_valid_q && out_stall_i;
    val_d         = val_q;
    taken_d       = taken_q;
    err_d         = err_q;
    in_top_min_d  = in_top_min_q;
    in_bot_d      = in_bot_q;
    out_top_val_d = out_top_val_q;
    out_top_min_d = out_top_min_q;
    res_taken_d   = res_taken_q;
    res_oldest_d  = res_oldest_q;
    res_least_d   = res_least_q;
    res_count_d   = res_count_q;
    res_error_d   = res_error_q;
    in_we         = 1'b0;
    out_we        = 1'b0;
    in_wdata      = {val_q, cmp_y};
    out_wdata     = {in_rd_val, cmp_y};
    cmp_a         = in_top_min_q;
    cmp_b         = out_top_min_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          taken_d = '0;
          err_d   = 1'b0;
          case (op_e'(operation_i))
            OP_ENQUEUE: begin
              if (count_w >= CapW) begin
                err_d   = 1'b1;
                state_d = S_RESULT;
              end else begin
                state_d = S_ENQ;
              end
            end
            OP_DEQUEUE: begin
              if (count_w == '0) begin
                err_d   = 1'b1;
                state_d = S_RESULT;
              end else if (out_depth_q == '0) begin
                state_d = S_XFER_RD;
              end else begin
                state_d = S_POP;
              end
            end
            OP_CLEAR: begin
              in_depth_d  = '0;
              out_depth_d = '0;
              state_d     = S_RESULT;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end
      S_ENQ: begin
        cmp_a   = val_q;
        cmp_b   = in_top_min_q;
        new_min = (in_depth_q == '0) ? val_q : cmp_y;
        in_we   = 1'b1;
        in_wdata = {val_q, new_min};
        in_top_min_d = new_min;
        if (in_depth_q == '0) begin
          in_bot_d = val_q;
        end
        in_depth_d = in_depth_q + One;
        state_d    = S_RESULT;
      end
      S_XFER_RD: begin
        state_d = S_XFER_WR;
      end
      S_XFER_WR: begin
        cmp_a   = in_rd_val;
        cmp_b   = out_top_min_q;
        new_min = (out_depth_q == '0) ? in_rd_val : cmp_y;
        out_we  = 1'b1;
        out_wdata = {in_rd_val, new_min};
        out_top_val_d = in_rd_val;
        out_top_min_d = new_min;
        in_depth_d    = in_dec;
        out_depth_d   = out_depth_q + One;
        state_d       = (in_dec == '0) ? S_POP : S_XFER_RD;
      end
      S_POP: begin
        taken_d     = out_top_val_q;
        out_depth_d = out_depth_q - One;
        state_d     = (out_depth_q == One) ? S_RESULT : S_POP_RD;
      end
      S_POP_RD: begin
        out_top_val_d = out_rd_val;
        out_top_min_d = out_rd_min;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          res_taken_d = taken_q;
          res_error_d = err_q;
          res_count_d = count_w;
          if (out_depth_q != '0) begin
            res_oldest_d = out_top_val_q;
          end else if (in_depth_q != '0) begin
            res_oldest_d = in_bot_q;
          end else begin
            res_oldest_d = '0;
          end
          if (in_depth_q != '0 && out_depth_q != '0) begin
            res_least_d = cmp_y;
          end else if (in_depth_q != '0) begin
            res_least_d = in_top_min_q;
          end else if (out_depth_q != '0) begin
            res_least_d = out_top_min_q;
          end else begin
            res_least_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_depth_q  <= '0;
      out_depth_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_depth_q  <= in_depth_d;
      out_depth_q <= out_depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q         <= val_d;
    taken_q       <= taken_d;
    err_q         <= err_d;
    in_top_min_q  <= in_top_min_d;
    in_bot_q      <= in_bot_d;
    out_top_val_q <= out_top_val_d;
    out_top_min_q <= out_top_min_d;
    res_taken_q   <= res_taken_d;
    res_oldest_q  <= res_oldest_d;
    res_least_q   <= res_least_d;
    res_count_q   <= res_count_d;
    res_error_q   <= res_error_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign taken_value_o  = res_taken_q;
  assign oldest_value_o = res_oldest_q;
  assign least_value_o  = res_least_q;
  assign count_o        = res_count_q;
  assign is_empty_o     = (res_count_q == '0);
  assign error_o        = res_error_q;

endmodule

>>> hw/rtl/mtf_smin.sv
// ----------------------------------------------------------------------------
// mtf_smin
// Shared signed minimum unit used by the S_ENQ, S_XFER_WR and S_RESULT steps.
// ----------------------------------------------------------------------------
module mtf_smin import mtf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] y_o
);

  assign y_o = (a_i < b_i) ? a_i : b_i;

endmodule

>>> hw/rtl/mtf_stack_ram.sv
// ----------------------------------------------------------------------------
// mtf_stack_ram
// Stack storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtf_stack_ram import mtf_pkg::*; #(
  parameter int unsigned WIDTH = 2 * DefDataWidth,
  parameter int unsigned DEPTH = DefCapacity,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
